// ===== rtl/lru_page_replacement_defines.svh =====
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define LRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define LRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lru_pkg.sv =====
`default_nettype none

package lru_pkg;

  localparam int FRAMES = 8;
  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  localparam int PAGE_W = 8;
  localparam int AGE_W  = 16;
  localparam int MISS_W = 32;
  localparam int CFG_W  = 4;
  localparam int FIDX_W = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic             match;
    logic             greater;
    logic [AGE_W-1:0] age_inc;
  } cmp_res_t;

endpackage

`default_nettype wire

// ===== rtl/lru_cmp.sv =====
`default_nettype none

module lru_cmp (
  input  logic [lru_pkg::PAGE_W-1:0] page_a_i,
  input  logic [lru_pkg::PAGE_W-1:0] page_b_i,
  input  logic [lru_pkg::AGE_W-1:0]  age_i,
  input  logic [lru_pkg::AGE_W-1:0]  best_age_i,
  output lru_pkg::cmp_res_t          res_o
);

  logic [lru_pkg::AGE_W-1:0] age_inc;

  always_comb begin
    if (age_i == '1) begin
      age_inc = age_i;
    end else begin
      age_inc = age_i + 1'b1;
    end
  end

  assign res_o.age_inc = age_inc;
  assign res_o.match   = (page_a_i == page_b_i);
  assign res_o.greater = (age_inc > best_age_i);

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// Channel  Dir  Handshake                Payload
// in       in   in_valid_i / in_ready_o  page_number_i
// out      out  out_valid_o / out_ready_i hit_o, frame_index_o, evicted_valid_o,
//                                         evicted_page_o, miss_total_o
// cfg      in   cfg_we_i                 cfg_wdata_i (frames_in_use)
//
// A reference is taken in idle, then scans the filled frames one per cycle through
// the shared age/compare unit, then moves to the update state and back to idle.
// The update cycle waits while the output register holds an untaken result.
// Asynchronous active-low reset empties all frames, clears ages and the miss count.
`default_nettype none

module lru_page_replacement (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lru_pkg::PAGE_W-1:0]  page_number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [lru_pkg::FIDX_W-1:0]  frame_index_o,
  output logic                        evicted_valid_o,
  output logic [lru_pkg::PAGE_W-1:0]  evicted_page_o,
  output logic [lru_pkg::MISS_W-1:0]  miss_total_o,
  input  logic                        cfg_we_i,
  input  logic [lru_pkg::CFG_W-1:0]   cfg_wdata_i
);

  `include "lru_page_replacement_defines.svh"

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE} state_e;

  state_e                       state_q;
  logic [lru_pkg::PAGE_W-1:0]   page_q;
  logic [lru_pkg::CNT_W-1:0]    idx_q;
  logic                         hit_q;
  logic [lru_pkg::IDX_W-1:0]    hit_idx_q;
  logic [lru_pkg::IDX_W-1:0]    best_idx_q;
  logic [lru_pkg::AGE_W-1:0]    best_age_q;
  logic [lru_pkg::CNT_W-1:0]    filled_q;
  logic [lru_pkg::MISS_W-1:0]   miss_q;
  logic [lru_pkg::CFG_W-1:0]    cfg_q;
  logic [lru_pkg::AGE_W-1:0]    frame_age_q [lru_pkg::FRAMES];
  logic [lru_pkg::PAGE_W-1:0]   frame_page_q [lru_pkg::FRAMES];

  logic                         out_valid_q;
  logic                         hit_out_q;
  logic [lru_pkg::FIDX_W-1:0]   frame_out_q;
  logic                         ev_valid_q;
  logic [lru_pkg::PAGE_W-1:0]   ev_page_q;
  logic [lru_pkg::MISS_W-1:0]   miss_out_q;

  logic [lru_pkg::IDX_W-1:0]    rd_idx;
  logic [lru_pkg::CNT_W-1:0]    cap;
  logic                         has_free;
  logic [lru_pkg::IDX_W-1:0]    wr_idx;
  logic                         out_free;
  logic                         commit;
  logic [lru_pkg::MISS_W-1:0]   miss_d;
  logic [lru_pkg::CNT_W-1:0]    idx_d;
  lru_pkg::cmp_res_t            cmp_res;

  assign rd_idx   = idx_q[lru_pkg::IDX_W-1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = (state_q == S_UPDATE) && out_free;
  assign idx_d    = idx_q + 1'b1;

  always_comb begin
    if (cfg_q == '0) begin
      cap = lru_pkg::CNT_W'(1);
    end else if (int'(cfg_q) > lru_pkg::FRAMES) begin
      cap = lru_pkg::CNT_W'(lru_pkg::FRAMES);
    end else begin
      cap = lru_pkg::CNT_W'(cfg_q);
    end
  end

  assign has_free = (filled_q < cap);
  assign wr_idx   = has_free ? filled_q[lru_pkg::IDX_W-1:0] : best_idx_q;
  assign miss_d   = (miss_q == '1) ? miss_q : miss_q + 1'b1;

  lru_cmp u_cmp (
    .page_a_i   (page_q),
    .page_b_i   (frame_page_q[rd_idx]),
    .age_i      (frame_age_q[rd_idx]),
    .best_age_i (best_age_q),
    .res_o      (cmp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      filled_q    <= '0;
      miss_q      <= '0;
      cfg_q       <= lru_pkg::CFG_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < lru_pkg::FRAMES; i++) begin
        frame_age_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_ready_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            page_q <= page_number_i;
            idx_q  <= '0;
            hit_q  <= 1'b0;
            state_q <= (filled_q == '0) ? S_UPDATE : S_SCAN;
          end
        end
        S_SCAN: begin
          frame_age_q[rd_idx] <= cmp_res.age_inc;
          if (cmp_res.match && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= rd_idx;
          end
          if (idx_q == '0 || cmp_res.greater) begin
            best_idx_q <= rd_idx;
            best_age_q <= cmp_res.age_inc;
          end
          idx_q <= idx_d;
          if (idx_d == filled_q) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (hit_q) begin
              frame_age_q[hit_idx_q] <= '0;
              hit_out_q   <= 1'b1;
              frame_out_q <= lru_pkg::FIDX_W'(hit_idx_q);
              ev_valid_q  <= 1'b0;
              ev_page_q   <= '0;
              miss_out_q  <= miss_q;
            end else begin
              frame_age_q[wr_idx] <= '0;
              miss_q      <= miss_d;
              miss_out_q  <= miss_d;
              hit_out_q   <= 1'b0;
              frame_out_q <= lru_pkg::FIDX_W'(wr_idx);
              if (has_free) begin
                filled_q   <= filled_q + 1'b1;
                ev_valid_q <= 1'b0;
                ev_page_q  <= '0;
              end else begin
                ev_valid_q <= 1'b1;
                ev_page_q  <= frame_page_q[best_idx_q];
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && !hit_q) begin
      frame_page_q[wr_idx] <= page_q;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_out_q;
  assign frame_index_o   = frame_out_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign miss_total_o    = miss_out_q;

  `LRU_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
    "block took a second reference while busy")
  `LRU_ASSERT_IMP(a_fill_step, filled_q != $past(filled_q),
    filled_q == $past(filled_q) + 1'b1, "filled count moved by other than one")
  `LRU_ASSERT_IMP(a_miss_on_update, miss_q != $past(miss_q),
    $past(state_q == S_UPDATE) && !$past(hit_q), "miss count moved outside a miss update")
  `LRU_ASSERT_IMP(a_evict_needs_frames, out_valid_o && evicted_valid_o,
    !hit_o && filled_q != '0, "eviction reported with hit or empty frames")

endmodule

`default_nettype wire
